// ===== sv/clbte_pkg.sv =====
// Shared types and constants for the character-LCD bus transaction engine.
// No dependencies; imported by every module of the block.
package clbte_pkg;

  // One input beat as seen on the push side.
  typedef struct packed {
    logic       opcode;
    logic       reg_select;
    logic [7:0] write_value;
    logic       busy_line;
  } in_item_t;

  // One result beat as seen on the pop side.
  typedef struct packed {
    logic       enable_line;
    logic       read_write_line;
    logic       reg_select_line;
    logic       data_drive;
    logic [7:0] data_out;
    logic       done_res;
    logic       rejected;
  } out_item_t;

  // Input opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Classified command handed from the front to the engine.
  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       reg_select;
    logic [7:0] write_value;
    logic       busy_line;
  } cmd_t;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 16;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FOUR_BIT_MODE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_DELAY   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_DELAY    = 2'd2;

  // Configuration reset values.
  localparam logic                      FOUR_BIT_RESET    = 1'b1;
  localparam logic [CFG_DATA_WIDTH-1:0] SHORT_DELAY_RESET = 16'd1;
  localparam logic [CFG_DATA_WIDTH-1:0] LONG_DELAY_RESET  = 16'd1520;

  typedef struct packed {
    logic                      four_bit_mode;
    logic [CFG_DATA_WIDTH-1:0] phase_ticks;
    logic [CFG_DATA_WIDTH-1:0] clear_wait_ticks;
  } cfg_t;

  // Instructions that need the long post-write delay.
  localparam logic [7:0] INSTR_CLEAR = 8'h01;
  localparam logic [7:0] INSTR_HOME  = 8'h02;

  // Bus sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_SAMPLE     = 4'd1,
    PH_DUMMY_RISE = 4'd2,
    PH_DUMMY_FALL = 4'd3,
    PH_RETRY      = 4'd4,
    PH_SETUP_HIGH = 4'd5,
    PH_HIGH_FALL  = 4'd6,
    PH_SETUP_LOW  = 4'd7,
    PH_LOW_FALL   = 4'd8,
    PH_LONG_DELAY = 4'd9
  } phase_t;

endpackage

// ===== sv/clbte_front.sv =====
// Front end: accepts input beats, classifies them and holds them in a
// two-entry command queue. Depends on clbte_pkg.
module clbte_front
  import clbte_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t item,
  output logic     full,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  cmd_t       classified;

  assign accept = push && !full;
  assign full   = (count == 2'd2);

  // Decode the opcode once here so the engine sees a command kind.
  always_comb begin
    classified.kind        = (item.opcode == OP_TICK) ? CMD_TICK : CMD_REQUEST;
    classified.reg_select  = item.reg_select;
    classified.write_value = item.write_value;
    classified.busy_line   = item.busy_line;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, accept} - {1'b0, cmd_pop};
    end
  end

  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];

endmodule

// ===== sv/clbte_engine.sv =====
// Back end: bus sequencer that runs one command per cycle, when the result queue has
// room, against the phase countdown and line registers. Depends on clbte_pkg.
module clbte_engine
  import clbte_pkg::*;
#(
  parameter int unsigned DELAY_COUNT_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      res_ready,
  output logic      res_push,
  output out_item_t res
);

  localparam int unsigned CW = DELAY_COUNT_WIDTH;

  phase_t          phase,      phase_next;
  logic [CW-1:0]   countdown,  countdown_next;
  logic            latched_select, latched_select_next;
  logic [7:0]      latched_byte,   latched_byte_next;
  logic            busy_seen,  busy_seen_next;
  logic            polling_after_write, polling_after_write_next;
  logic            e_line,     e_line_next;
  logic            rw_line,    rw_line_next;
  logic            rs_line,    rs_line_next;
  logic            drive,      drive_next;
  logic [7:0]      data,       data_next;
  logic            done;
  logic            rej;
  logic            fire;
  logic            count_low;
  logic            go_poll;
  logic            go_after_read;
  logic            go_after_write;
  logic            is_long;
  logic [CW-1:0]   short_load;
  logic [CW-1:0]   long_load;

  // Saturate the 16-bit delay registers into the countdown width.
  if (CW >= CFG_DATA_WIDTH) begin : g_wide
    assign short_load = CW'(cfg.phase_ticks);
    assign long_load  = CW'(cfg.clear_wait_ticks);
  end else begin : g_narrow
    assign short_load = (|cfg.phase_ticks[CFG_DATA_WIDTH-1:CW]) ? '1
                        : cfg.phase_ticks[CW-1:0];
    assign long_load  = (|cfg.clear_wait_ticks[CFG_DATA_WIDTH-1:CW]) ? '1
                        : cfg.clear_wait_ticks[CW-1:0];
  end

  assign fire      = cmd_valid && res_ready;
  assign cmd_pop   = fire;
  assign res_push  = fire;
  assign count_low = (countdown[CW-1:1] == '0);
  assign is_long   = !latched_select &&
                     (latched_byte == INSTR_CLEAR || latched_byte == INSTR_HOME);

  always_comb begin
    phase_next               = phase;
    countdown_next           = countdown;
    latched_select_next      = latched_select;
    latched_byte_next        = latched_byte;
    busy_seen_next           = busy_seen;
    polling_after_write_next = polling_after_write;
    e_line_next              = e_line;
    rw_line_next             = rw_line;
    rs_line_next             = rs_line;
    drive_next               = drive;
    data_next                = data;
    done                     = 1'b0;
    rej                      = 1'b0;
    go_poll                  = 1'b0;
    go_after_read            = 1'b0;
    go_after_write           = 1'b0;

    if (cmd.kind == CMD_REQUEST) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        latched_select_next      = cmd.reg_select;
        latched_byte_next        = cmd.write_value;
        busy_seen_next           = 1'b0;
        polling_after_write_next = 1'b0;
        go_poll                  = 1'b1;
      end
    end else if (phase != PH_IDLE) begin
      if (!count_low) begin
        countdown_next = countdown - 1'b1;
      end else begin
        countdown_next = '0;
        unique case (phase)
          PH_SAMPLE: begin
            busy_seen_next = cmd.busy_line;
            e_line_next    = 1'b0;
            if (cfg.four_bit_mode) begin
              phase_next     = PH_DUMMY_RISE;
              countdown_next = short_load;
            end else begin
              go_after_read = 1'b1;
            end
          end
          PH_DUMMY_RISE: begin
            e_line_next    = 1'b1;
            phase_next     = PH_DUMMY_FALL;
            countdown_next = short_load;
          end
          PH_DUMMY_FALL: begin
            e_line_next   = 1'b0;
            go_after_read = 1'b1;
          end
          PH_RETRY: begin
            go_poll = 1'b1;
          end
          PH_SETUP_HIGH: begin
            drive_next     = 1'b1;
            rw_line_next   = 1'b0;
            rs_line_next   = latched_select;
            data_next      = cfg.four_bit_mode ? {4'b0000, latched_byte[7:4]}
                                               : latched_byte;
            e_line_next    = 1'b1;
            phase_next     = PH_HIGH_FALL;
            countdown_next = short_load;
          end
          PH_HIGH_FALL: begin
            e_line_next = 1'b0;
            if (cfg.four_bit_mode) begin
              phase_next     = PH_SETUP_LOW;
              countdown_next = short_load;
            end else begin
              go_after_write = 1'b1;
            end
          end
          PH_SETUP_LOW: begin
            data_next      = {4'b0000, latched_byte[3:0]};
            e_line_next    = 1'b1;
            phase_next     = PH_LOW_FALL;
            countdown_next = short_load;
          end
          PH_LOW_FALL: begin
            e_line_next    = 1'b0;
            go_after_write = 1'b1;
          end
          PH_LONG_DELAY: begin
            polling_after_write_next = 1'b1;
            go_poll                  = 1'b1;
          end
          default: begin
            phase_next               = PH_IDLE;
            polling_after_write_next = 1'b0;
          end
        endcase
      end
    end

    // Busy read finished: retry, complete the post-write poll, or write.
    if (go_after_read) begin
      if (busy_seen_next) begin
        phase_next     = PH_RETRY;
        countdown_next = short_load;
      end else if (polling_after_write) begin
        phase_next               = PH_IDLE;
        polling_after_write_next = 1'b0;
        done                     = 1'b1;
      end else begin
        phase_next     = PH_SETUP_HIGH;
        countdown_next = short_load;
      end
    end

    // Byte written: clear and home wait long, everything else completes.
    if (go_after_write) begin
      if (is_long) begin
        phase_next     = PH_LONG_DELAY;
        countdown_next = long_load;
      end else begin
        phase_next               = PH_IDLE;
        polling_after_write_next = 1'b0;
        done                     = 1'b1;
      end
    end

    // Start a busy-flag read: release data, RW high, RS low, raise E.
    if (go_poll) begin
      drive_next     = 1'b0;
      data_next      = 8'h00;
      rw_line_next   = 1'b1;
      rs_line_next   = 1'b0;
      e_line_next    = 1'b1;
      phase_next     = PH_SAMPLE;
      countdown_next = short_load;
    end
  end

  always_comb begin
    res.enable_line     = e_line_next;
    res.read_write_line = rw_line_next;
    res.reg_select_line = rs_line_next;
    res.data_drive      = drive_next;
    res.data_out        = drive_next ? data_next : 8'h00;
    res.done_res        = done;
    res.rejected        = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      countdown           <= '0;
      latched_select      <= 1'b0;
      latched_byte        <= 8'h00;
      busy_seen           <= 1'b0;
      polling_after_write <= 1'b0;
      e_line              <= 1'b0;
      rw_line             <= 1'b0;
      rs_line             <= 1'b0;
      drive               <= 1'b0;
      data                <= 8'h00;
    end else if (fire) begin
      phase               <= phase_next;
      countdown           <= countdown_next;
      latched_select      <= latched_select_next;
      latched_byte        <= latched_byte_next;
      busy_seen           <= busy_seen_next;
      polling_after_write <= polling_after_write_next;
      e_line              <= e_line_next;
      rw_line             <= rw_line_next;
      rs_line             <= rs_line_next;
      drive               <= drive_next;
      data                <= data_next;
    end
  end

endmodule

// ===== sv/clbte_resq.sv =====
// Result queue: two-entry buffer between the engine and the pop side.
// Depends on clbte_pkg.
module clbte_resq
  import clbte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      res_push,
  input  out_item_t res,
  output logic      res_ready,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  out_item_t  queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       take;

  assign res_ready = (count != 2'd2);
  assign empty     = (count == 2'd0);
  assign take      = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_push) begin
      queue[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, res_push} - {1'b0, take};
    end
  end

  assign result = queue[rd_ptr];

endmodule

// ===== sv/char_lcd_bus_transaction_engine.sv =====
// Flow: a beat accepted into the command queue is handled by the bus sequencer
//   once the result queue has room; its result is then held there until popped.
// Rate: one beat per cycle sustained while the result side keeps popping; each beat
//   passes the command queue, the bus sequencer and the result queue.
// Reset (rst, synchronous, active high): queues empty, sequencer idle with all
//   lines low and data released, configuration back to its reset values.
module char_lcd_bus_transaction_engine
  import clbte_pkg::*;
#(
  parameter int unsigned DELAY_COUNT_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // Input side: push a request or a tick beat.
  input  logic                       push,
  input  in_item_t                   item,
  output logic                       full,
  // Result side: one result beat per input beat.
  output logic                       empty,
  input  logic                       pop,
  output out_item_t                  result,
  // Configuration write port.
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  cfg_t      cfg;
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      res_ready;
  logic      res_push;
  out_item_t res;

  // Configuration registers; to be written by the user only while no beat is in flight
  // (the block does not enforce this), so the sequencer can read them directly at each decision.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.four_bit_mode    <= FOUR_BIT_RESET;
      cfg.phase_ticks      <= SHORT_DELAY_RESET;
      cfg.clear_wait_ticks <= LONG_DELAY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FOUR_BIT_MODE: cfg.four_bit_mode    <= cfg_data[0];
        REG_SHORT_DELAY:   cfg.phase_ticks      <= cfg_data;
        REG_LONG_DELAY:    cfg.clear_wait_ticks <= cfg_data;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Front: accept and classify beats, hold them until the sequencer is free.
  clbte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back: take or reject requests, advance the countdown or act on the current bus phase.
  clbte_engine #(
    .DELAY_COUNT_WIDTH (DELAY_COUNT_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res       (res)
  );

  // Hold finished results until the consumer pops them.
  clbte_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .res_push  (res_push),
    .res       (res),
    .res_ready (res_ready),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // A beat cannot both complete a transaction and be rejected.
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(result.done_res && result.rejected))
    else $error("result beat both done and rejected");

  // Released data lines always read as zero.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.data_drive) |-> (result.data_out == 8'h00))
    else $error("data_out nonzero while data lines released");

  // The input queue fills only after a push.
  assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("input queue filled without a push");

  // A result appears only after the sequencer handled a command.
  assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(cmd_valid && res_ready))
    else $error("result appeared without a sequencer step");

endmodule

// ===== dv/char_lcd_bus_transaction_engine_checker.sv =====
`timescale 1ns / 100ps
// Checker for the LCD bus engine: predicts each result beat and compares it.
// Watches the push, pop and configuration ports. Depends on clbte_pkg.
module char_lcd_bus_transaction_engine_checker
  import clbte_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  in_item_t                   item,
  input  logic                       full,
  input  logic                       empty,
  input  logic                       pop,
  input  out_item_t                  result,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output int unsigned                mismatches,
  output int unsigned                beats_due,
  output logic                       bus_idle,
  output int unsigned                writes_done,
  output int unsigned                requests_rejected,
  output int unsigned                beats_checked
);

  cfg_t        cfg_model;
  phase_t      seq_phase;
  logic [15:0] ticks_left;
  logic        sel_held;
  logic [7:0]  byte_held;
  logic        busy_held;
  logic        final_poll;
  logic        e_lvl, rw_lvl, rs_lvl, drive_lvl;
  logic [7:0]  data_lvl;
  logic        write_done;
  out_item_t   bus_levels_due[$];
  int unsigned n_bad, n_done, n_rejected, n_checked;

  task automatic start_busy_poll();
    drive_lvl  = 1'b0;
    data_lvl   = 8'h00;
    rw_lvl     = 1'b1;
    rs_lvl     = 1'b0;
    e_lvl      = 1'b1;
    seq_phase  = PH_SAMPLE;
    ticks_left = cfg_model.phase_ticks;
  endtask

  task automatic close_write();
    seq_phase  = PH_IDLE;
    final_poll = 1'b0;
    write_done = 1'b1;
  endtask

  task automatic after_busy_read();
    if (busy_held) begin
      seq_phase  = PH_RETRY;
      ticks_left = cfg_model.phase_ticks;
    end else if (final_poll) begin
      close_write();
    end else begin
      seq_phase  = PH_SETUP_HIGH;
      ticks_left = cfg_model.phase_ticks;
    end
  endtask

  task automatic after_byte_written();
    if (!sel_held && (byte_held == INSTR_CLEAR || byte_held == INSTR_HOME)) begin
      seq_phase  = PH_LONG_DELAY;
      ticks_left = cfg_model.clear_wait_ticks;
    end else begin
      close_write();
    end
  endtask

  // Perform the action of the current phase once its countdown expires.
  task automatic run_phase(input logic busy);
    case (seq_phase)
      PH_SAMPLE: begin
        busy_held = busy;
        e_lvl     = 1'b0;
        if (cfg_model.four_bit_mode) begin
          seq_phase  = PH_DUMMY_RISE;
          ticks_left = cfg_model.phase_ticks;
        end else begin
          after_busy_read();
        end
      end
      PH_DUMMY_RISE: begin
        e_lvl      = 1'b1;
        seq_phase  = PH_DUMMY_FALL;
        ticks_left = cfg_model.phase_ticks;
      end
      PH_DUMMY_FALL: begin
        e_lvl = 1'b0;
        after_busy_read();
      end
      PH_RETRY: start_busy_poll();
      PH_SETUP_HIGH: begin
        drive_lvl  = 1'b1;
        rw_lvl     = 1'b0;
        rs_lvl     = sel_held;
        data_lvl   = cfg_model.four_bit_mode ? {4'h0, byte_held[7:4]} : byte_held;
        e_lvl      = 1'b1;
        seq_phase  = PH_HIGH_FALL;
        ticks_left = cfg_model.phase_ticks;
      end
      PH_HIGH_FALL: begin
        e_lvl = 1'b0;
        if (cfg_model.four_bit_mode) begin
          seq_phase  = PH_SETUP_LOW;
          ticks_left = cfg_model.phase_ticks;
        end else begin
          after_byte_written();
        end
      end
      PH_SETUP_LOW: begin
        data_lvl   = {4'h0, byte_held[3:0]};
        e_lvl      = 1'b1;
        seq_phase  = PH_LOW_FALL;
        ticks_left = cfg_model.phase_ticks;
      end
      PH_LOW_FALL: begin
        e_lvl = 1'b0;
        after_byte_written();
      end
      PH_LONG_DELAY: begin
        final_poll = 1'b1;
        start_busy_poll();
      end
      default: begin
        seq_phase  = PH_IDLE;
        final_poll = 1'b0;
      end
    endcase
  endtask

  // Advance the sequencer by one beat and return the bus levels it leaves.
  task automatic step_bus_engine(input in_item_t b, output out_item_t levels);
    logic reject;
    reject     = 1'b0;
    write_done = 1'b0;
    if (b.opcode == OP_WRITE) begin
      if (seq_phase != PH_IDLE) begin
        reject = 1'b1;
      end else begin
        sel_held   = b.reg_select;
        byte_held  = b.write_value;
        busy_held  = 1'b0;
        final_poll = 1'b0;
        start_busy_poll();
      end
    end else if (seq_phase != PH_IDLE) begin
      if (ticks_left <= 16'd1) begin
        ticks_left = 16'd0;
        run_phase(b.busy_line);
      end else begin
        ticks_left = ticks_left - 16'd1;
      end
    end
    levels.enable_line     = e_lvl;
    levels.read_write_line = rw_lvl;
    levels.reg_select_line = rs_lvl;
    levels.data_drive      = drive_lvl;
    levels.data_out        = drive_lvl ? data_lvl : 8'h00;
    levels.done_res        = write_done;
    levels.rejected        = reject;
  endtask

  function automatic bit field_ok(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want)
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    return got === want;
  endfunction

  always @(posedge clk) begin
    out_item_t levels;
    out_item_t want;
    bit        ok;
    if (rst) begin
      cfg_model.four_bit_mode    = FOUR_BIT_RESET;
      cfg_model.phase_ticks      = SHORT_DELAY_RESET;
      cfg_model.clear_wait_ticks = LONG_DELAY_RESET;
      seq_phase  = PH_IDLE;
      ticks_left = 16'd0;
      sel_held   = 1'b0;
      byte_held  = 8'h00;
      busy_held  = 1'b0;
      final_poll = 1'b0;
      {e_lvl, rw_lvl, rs_lvl, drive_lvl} = 4'b0000;
      data_lvl   = 8'h00;
      write_done = 1'b0;
      bus_levels_due.delete();
      n_bad = 0;
      n_done = 0;
      n_rejected = 0;
      n_checked = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FOUR_BIT_MODE: cfg_model.four_bit_mode    = cfg_data[0];
          REG_SHORT_DELAY:   cfg_model.phase_ticks      = cfg_data;
          REG_LONG_DELAY:    cfg_model.clear_wait_ticks = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        step_bus_engine(item, levels);
        bus_levels_due.push_back(levels);
      end
      if (pop && !empty) begin
        n_checked++;
        if (bus_levels_due.size() == 0) begin
          n_bad++;
          $display("%0t: result beat 0x%0h arrived with nothing expected", $time, result);
        end else begin
          want = bus_levels_due.pop_front();
          n_done     += 32'(want.done_res);
          n_rejected += 32'(want.rejected);
          ok = field_ok("enable_line", 8'(want.enable_line), 8'(result.enable_line))
             & field_ok("read_write_line", 8'(want.read_write_line),
                        8'(result.read_write_line))
             & field_ok("reg_select_line", 8'(want.reg_select_line),
                        8'(result.reg_select_line))
             & field_ok("data_drive", 8'(want.data_drive), 8'(result.data_drive))
             & field_ok("data_out", want.data_out, result.data_out)
             & field_ok("done_res", 8'(want.done_res), 8'(result.done_res))
             & field_ok("rejected", 8'(want.rejected), 8'(result.rejected));
          if (!ok) n_bad++;
        end
      end
    end
    mismatches        <= n_bad;
    beats_due         <= bus_levels_due.size();
    bus_idle          <= (seq_phase == PH_IDLE);
    writes_done       <= n_done;
    requests_rejected <= n_rejected;
    beats_checked     <= n_checked;
  end

endmodule

// ===== dv/char_lcd_bus_transaction_engine_tb.sv =====
`timescale 1ns / 100ps
// Top of the LCD bus engine testbench: clock, reset, stimulus and verdict.
// Depends on clbte_pkg, the engine and char_lcd_bus_transaction_engine_checker.
module char_lcd_bus_transaction_engine_tb;
  import clbte_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_500_000;
  localparam int unsigned SETTLE_CYCLES   = 8;    // well past the pipeline latency
  localparam int unsigned HOLD_OFF_CYCLES = 400;  // long enough to fill both queues
  localparam int unsigned PHASE_BEATS     = 228;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  in_item_t                   item = '0;
  logic                       full;
  logic                       empty;
  logic                       pop = 1'b0;
  out_item_t                  result;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  int unsigned mismatches, beats_due, writes_done, requests_rejected, beats_checked;
  logic        bus_idle;

  // Idle rates in percent, changed per phase; a hold-off is asked by bumping
  // the request count, and the pop process serves it.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_off_requests = 0;
  int unsigned hold_off_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  always #2 clk = ~clk;

  char_lcd_bus_transaction_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  char_lcd_bus_transaction_engine_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .item              (item),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .result            (result),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .beats_due         (beats_due),
    .bus_idle          (bus_idle),
    .writes_done       (writes_done),
    .requests_rejected (requests_rejected),
    .beats_checked     (beats_checked)
  );

  // Result side: stall at random, or hold pop low for a counted stretch when
  // a hold-off is asked; the sender keeps going meanwhile.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_off_served != hold_off_requests) begin
      hold_off_served <= hold_off_requests;
      hold_left       <= HOLD_OFF_CYCLES;
      pop             <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one beat, maybe after a random gap, and hold it until accepted.
  // Reads of full right after the edge see the level the edge used.
  task automatic send_beat(input in_item_t b);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    item <= b;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_tick(input logic busy);
    in_item_t b;
    b             = '0;
    b.opcode      = OP_TICK;
    b.busy_line   = busy;
    b.write_value = 8'($urandom_range(255));
    send_beat(b);
  endtask

  task automatic send_request(input logic sel, input logic [7:0] value, input logic busy);
    in_item_t b;
    b.opcode      = OP_WRITE;
    b.reg_select  = sel;
    b.write_value = value;
    b.busy_line   = busy;
    send_beat(b);
  endtask

  // Tick with a ready display until the sequencer is back to idle. The idle
  // flag lags one beat, so at most one idle tick goes out at the end.
  task automatic finish_write();
    do send_tick(1'b0); while (!bus_idle);
  endtask

  // Drop push, then let every outstanding result come back before moving on.
  task automatic wait_quiet();
    push <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges, write enable held high.
  task automatic write_config(input logic nibble_mode, input logic [15:0] short_ticks,
                              input logic [15:0] long_ticks);
    cfg_write <= 1'b1;
    cfg_index <= REG_FOUR_BIT_MODE;
    cfg_data  <= {15'd0, nibble_mode};
    @(posedge clk);
    cfg_index <= REG_SHORT_DELAY;
    cfg_data  <= short_ticks;
    @(posedge clk);
    cfg_index <= REG_LONG_DELAY;
    cfg_data  <= long_ticks;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly ticks, so writes run to completion; requests lean toward clear
  // and home on the instruction register to reach the long delay path.
  function automatic in_item_t random_beat();
    in_item_t b;
    b.busy_line   = ($urandom_range(99) < 25);
    b.reg_select  = 1'($urandom_range(1));
    b.write_value = 8'($urandom_range(255));
    b.opcode      = ($urandom_range(99) < 78) ? OP_TICK : OP_WRITE;
    if (b.opcode == OP_WRITE) begin
      case ($urandom_range(5))
        0: begin b.reg_select = 1'b0; b.write_value = INSTR_CLEAR; end
        1: begin b.reg_select = 1'b0; b.write_value = INSTR_HOME;  end
        default: ;
      endcase
    end
    return b;
  endfunction

  initial begin
    // Per phase: bus mode, short and long delays, sender gap, receiver stall.
    logic        modes[5];
    logic [15:0] shorts[5];
    logic [15:0] longs[5];
    int unsigned gaps[5];
    int unsigned stalls[5];

    modes  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    shorts = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1};
    longs  = '{16'd3, 16'd1, 16'd7, 16'd2, 16'd1};
    gaps   = '{0, 51, 0, 29, 0};
    stalls = '{0, 0, 51, 29, 0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: nibble mode, one tick per phase. Tick while idle, a
    // data write that sees busy once, and a request rejected mid-write.
    send_tick(1'b1);
    send_request(1'b1, 8'hA5, 1'b0);
    send_request(1'b0, 8'hFF, 1'b1);
    repeat (4) send_tick(1'b1);   // busy read, dummy pulse, retry
    repeat (7) send_tick(1'b0);   // clean read, then both nibbles
    wait_quiet();

    // Byte mode, zero short delay, shortest long delay: clear with a busy
    // final poll, then home with a mode change in the middle of its write.
    write_config(1'b0, 16'd0, 16'd1);
    send_request(1'b0, INSTR_CLEAR, 1'b0);
    repeat (4) send_tick(1'b0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    send_request(1'b0, INSTR_HOME, 1'b1);
    repeat (2) send_tick(1'b0);
    wait_quiet();
    write_config(1'b1, 16'd0, 16'd1);
    finish_write();
    wait_quiet();

    // Longer delays: a multi-tick byte write, then a long clear wait.
    write_config(1'b0, 16'd24, 16'd300);
    send_request(1'b1, 8'h00, 1'b0);
    finish_write();
    wait_quiet();
    write_config(1'b1, 16'd1, 16'd300);
    send_request(1'b0, INSTR_CLEAR, 1'b0);
    finish_write();
    wait_quiet();

    // Random traffic under each idling pattern; the last phase parks the
    // receiver long enough to back the engine up to full.
    for (int p = 0; p < 5; p++) begin
      write_config(modes[p], shorts[p], longs[p]);
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      if (p == 4) hold_off_requests++;
      repeat (PHASE_BEATS) send_beat(random_beat());
      wait_quiet();
    end

    $display("Checked %0d result beats: %0d completed writes, %0d rejected requests,",
             beats_checked, writes_done, requests_rejected);
    $display("both bus widths, zero and multi-tick delays, five idling patterns.");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
